>>> hdl/docq_pkg.sv
// Shared types and constants for the drop-oldest chunk descriptor queue.
// Used by docq_ctrl, docq_dpath and drop_oldest_chunk_queue_top.
package docq_pkg;

  localparam int unsigned CHUNK_DEPTH     = 64;
  localparam int unsigned IDX_W           = $clog2(CHUNK_DEPTH);
  localparam int unsigned CNT_W           = $clog2(CHUNK_DEPTH + 1);
  localparam int unsigned SAMPLE_CAPACITY = 1048576;
  localparam int unsigned SAMP_W          = $clog2(SAMPLE_CAPACITY + 1);
  localparam int unsigned PROD_W          = 54;  // trim * 1e9 fits in 54 bits
  localparam int unsigned DIVC_W          = $clog2(PROD_W);
  localparam logic [29:0] NS_PER_SEC      = 30'd1000000000;
  localparam logic [63:0] I64_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_RESTART = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_INVALID   = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_DONE      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_CHUNK_LIMIT  = 2'd0,
    REG_SAMPLE_LIMIT = 2'd1,
    REG_RATE_MIN     = 2'd2,
    REG_RATE_MAX     = 2'd3
  } reg_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [23:0]        chunk_length;
    logic [31:0]        chunk_rate;
    logic signed [63:0] chunk_start_ns;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [20:0]        out_length;
    logic [31:0]        out_rate;
    logic signed [63:0] out_start_ns;
    logic [6:0]         queued_chunks;
    logic [20:0]        queued_samples;
    logic [63:0]        dropped_chunks;
    logic [63:0]        dropped_samples;
    logic [63:0]        rejected_chunks;
    logic [63:0]        enqueued_samples;
    logic [63:0]        dequeued_samples;
    logic               is_cancelled;
  } out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    mul;
    logic    div_step;
    logic    fix;
    logic    drop;
    logic    write;
    logic    pop;
    logic    set_cancel;
    logic    clr_cancel;
    logic    clear;
    logic    reject;
    logic    emit;
    status_e status;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       invalid;
    logic       cancelled;
    logic       trim_nz;
    logic       drop_needed;
    logic       empty;
    logic       div_last;
    logic       out_busy;
  } sts_t;

endpackage

>>> hdl/docq_dpath.sv
// Datapath: config registers, descriptor memories, counters, divider, output register.
// Depends on docq_pkg.
module docq_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  docq_pkg::in_t   in_data_i,
  input  docq_pkg::cmd_t  cmd_i,
  output docq_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output docq_pkg::out_t  out_data_o
);
  import docq_pkg::*;

  logic [6:0]  chunk_limit_q;
  logic [20:0] sample_limit_q;
  logic [31:0] rate_min_q, rate_max_q;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_limit_q  <= 7'd64;
      sample_limit_q <= 21'd1048576;
      rate_min_q     <= 32'd8000;
      rate_max_q     <= 32'd192000;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_CHUNK_LIMIT:  chunk_limit_q  <= cfg_data_i[6:0];
        REG_SAMPLE_LIMIT: sample_limit_q <= cfg_data_i[20:0];
        REG_RATE_MIN:     rate_min_q     <= cfg_data_i;
        REG_RATE_MAX:     rate_max_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective limits
  logic [CNT_W-1:0]  clim;
  logic [SAMP_W-1:0] slim;
  logic [31:0]       rmin;
  always_comb begin
    if (chunk_limit_q == 7'd0) clim = CNT_W'(1);
    else if (chunk_limit_q > 7'(CHUNK_DEPTH)) clim = CNT_W'(CHUNK_DEPTH);
    else clim = CNT_W'(chunk_limit_q);
    if (sample_limit_q == 21'd0) slim = SAMP_W'(1);
    else if (sample_limit_q > 21'(SAMPLE_CAPACITY)) slim = SAMP_W'(SAMPLE_CAPACITY);
    else slim = SAMP_W'(sample_limit_q);
    rmin = (rate_min_q == 32'd0) ? 32'd1 : rate_min_q;
  end

  // Item registers
  logic [2:0]  op_q;
  logic [23:0] len_q;
  logic [31:0] rate_q;
  logic [63:0] start_q;
  logic [23:0] trim_q;

  // Queue state
  logic [IDX_W-1:0]  head_q;
  logic [CNT_W-1:0]  count_q;
  logic [SAMP_W-1:0] total_q;
  logic              cancel_q;
  logic [63:0] drop_ch_q, drop_sa_q, reject_q, enq_sa_q, deq_sa_q;

  // Divider
  logic [PROD_W-1:0] prod_q;
  logic [32:0]       rem_q;
  logic [DIVC_W-1:0] divc_q;

  // Memories
  logic [20:0] mem_len   [CHUNK_DEPTH];
  logic [31:0] mem_rate  [CHUNK_DEPTH];
  logic [63:0] mem_start [CHUNK_DEPTH];
  logic [20:0] rd_len_q;
  logic [31:0] rd_rate_q;
  logic [63:0] rd_start_q;

  // Popped descriptor
  logic [20:0] pop_len_q;
  logic [31:0] pop_rate_q;
  logic [63:0] pop_start_q;

  logic              out_valid_q;
  out_t              out_q;

  logic [23:0]       trim;
  logic [IDX_W-1:0]  slot;
  logic [32:0]       rem_sh;
  logic              ge;
  logic [64:0]       sum65;
  logic [63:0]       sat_start;

  // Trim, slot, divide step and saturating start
  always_comb begin
    trim   = (len_q > 24'(slim)) ? (len_q - 24'(slim)) : 24'd0;
    slot   = head_q + count_q[IDX_W-1:0];
    rem_sh = {rem_q[31:0], prod_q[PROD_W-1]};
    ge     = (rem_sh >= {1'b0, rate_q});
    sum65  = {start_q[63], start_q} + {{(65-PROD_W){1'b0}}, prod_q};
    sat_start = (sum65[64] != sum65[63]) ? I64_MAX : sum65[63:0];
  end

  // Status to controller
  always_comb begin
    sts_o.opcode      = op_q;
    sts_o.invalid     = (len_q == 24'd0) || (rate_q < rmin) || (rate_q > rate_max_q);
    sts_o.cancelled   = cancel_q;
    sts_o.trim_nz     = (trim != 24'd0);
    sts_o.drop_needed = (count_q >= clim) ||
                        ((count_q != '0) && (total_q > (slim - SAMP_W'(len_q))));
    sts_o.empty       = (count_q == '0);
    sts_o.div_last    = (divc_q == DIVC_W'(PROD_W - 1));
    sts_o.out_busy    = out_valid_q && !out_ready_i;
  end

  // Capture item and run arithmetic; hold the trimmed sample count for the statistics
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_data_i.opcode;
      len_q   <= in_data_i.chunk_length;
      rate_q  <= in_data_i.chunk_rate;
      start_q <= in_data_i.chunk_start_ns;
      trim_q  <= '0;
    end else if (cmd_i.fix) begin
      len_q   <= 24'(slim);
      start_q <= sat_start;
      trim_q  <= trim;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(trim) * PROD_W'(NS_PER_SEC);
      rem_q  <= '0;
      divc_q <= '0;
    end else if (cmd_i.div_step) begin
      prod_q <= {prod_q[PROD_W-2:0], ge};
      rem_q  <= ge ? (rem_sh - {1'b0, rate_q}) : rem_sh;
      divc_q <= divc_q + DIVC_W'(1);
    end
  end

  // Descriptor memories, head read every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem_len[slot]   <= len_q[20:0];
      mem_rate[slot]  <= rate_q;
      mem_start[slot] <= start_q;
    end
    rd_len_q   <= mem_len[head_q];
    rd_rate_q  <= mem_rate[head_q];
    rd_start_q <= mem_start[head_q];
  end

  // Popped fields, zero for any other result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pop_len_q   <= '0;
      pop_rate_q  <= '0;
      pop_start_q <= '0;
    end else if (cmd_i.pop) begin
      pop_len_q   <= rd_len_q;
      pop_rate_q  <= rd_rate_q;
      pop_start_q <= rd_start_q;
    end
  end

  // Queue occupancy, flag and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      total_q   <= '0;
      cancel_q  <= 1'b0;
      drop_ch_q <= '0;
      drop_sa_q <= '0;
      reject_q  <= '0;
      enq_sa_q  <= '0;
      deq_sa_q  <= '0;
    end else if (cmd_i.clear) begin
      head_q    <= '0;
      count_q   <= '0;
      total_q   <= '0;
      cancel_q  <= 1'b0;
      drop_ch_q <= '0;
      drop_sa_q <= '0;
      reject_q  <= '0;
      enq_sa_q  <= '0;
      deq_sa_q  <= '0;
    end else begin
      if (cmd_i.set_cancel) cancel_q <= 1'b1;
      if (cmd_i.clr_cancel) cancel_q <= 1'b0;
      if (cmd_i.reject) reject_q <= reject_q + 64'd1;
      if (cmd_i.drop) begin
        head_q    <= head_q + IDX_W'(1);
        count_q   <= count_q - CNT_W'(1);
        total_q   <= total_q - SAMP_W'(rd_len_q);
        drop_ch_q <= drop_ch_q + 64'd1;
        drop_sa_q <= drop_sa_q + 64'(rd_len_q);
      end
      if (cmd_i.pop) begin
        head_q   <= head_q + IDX_W'(1);
        count_q  <= count_q - CNT_W'(1);
        total_q  <= total_q - SAMP_W'(rd_len_q);
        deq_sa_q <= deq_sa_q + 64'(rd_len_q);
      end
      if (cmd_i.write) begin
        count_q   <= count_q + CNT_W'(1);
        total_q   <= total_q + SAMP_W'(len_q);
        drop_sa_q <= drop_sa_q + 64'(trim_q);
        enq_sa_q  <= enq_sa_q + 64'(len_q);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status           <= cmd_i.status;
      out_q.out_length       <= pop_len_q;
      out_q.out_rate         <= pop_rate_q;
      out_q.out_start_ns     <= pop_start_q;
      out_q.queued_chunks    <= 7'(count_q);
      out_q.queued_samples   <= 21'(total_q);
      out_q.dropped_chunks   <= drop_ch_q;
      out_q.dropped_samples  <= drop_sa_q;
      out_q.rejected_chunks  <= reject_q;
      out_q.enqueued_samples <= enq_sa_q;
      out_q.dequeued_samples <= deq_sa_q;
      out_q.is_cancelled     <= cancel_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/docq_ctrl.sv
// Controller: sequences decode, trim division, eviction, write or pop, and result.
// Depends on docq_pkg.
module docq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  docq_pkg::sts_t sts_i,
  output docq_pkg::cmd_t cmd_o
);
  import docq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_DIV, S_FIX, S_EV_CHK, S_EV_WAIT, S_FINISH
  } state_e;

  state_e  state_q;
  status_e status_q;

  assign in_ready_o = (state_q == S_IDLE);

  // Command decode per state
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = status_q;
    case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i;
      S_DECODE: begin
        case (op_e'(sts_i.opcode))
          OP_PUSH:    cmd_o.reject = sts_i.invalid || sts_i.cancelled;
          OP_POP:     cmd_o.pop    = !sts_i.empty;
          OP_CANCEL:  cmd_o.set_cancel = 1'b1;
          OP_RESTART: cmd_o.clr_cancel = 1'b1;
          OP_CLEAR:   cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      S_MUL:    cmd_o.mul      = 1'b1;
      S_DIV:    cmd_o.div_step = 1'b1;
      S_FIX:    cmd_o.fix      = 1'b1;
      S_EV_CHK: begin
        cmd_o.drop  = sts_i.drop_needed;
        cmd_o.write = !sts_i.drop_needed;
      end
      S_FINISH: cmd_o.emit = !sts_i.out_busy;
      default: ;
    endcase
  end

  // Advance state and hold result status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_DONE;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DECODE;
        S_DECODE: begin
          state_q  <= S_FINISH;
          status_q <= ST_DONE;
          case (op_e'(sts_i.opcode))
            OP_PUSH: begin
              if (sts_i.invalid) begin
                status_q <= ST_INVALID;
              end else if (sts_i.cancelled) begin
                status_q <= ST_CANCELLED;
              end else begin
                status_q <= ST_ACCEPTED;
                state_q  <= sts_i.trim_nz ? S_MUL : S_EV_CHK;
              end
            end
            OP_POP: status_q <= sts_i.empty ? ST_EMPTY : ST_POPPED;
            default: ;
          endcase
        end
        S_MUL: state_q <= S_DIV;
        S_DIV: if (sts_i.div_last) state_q <= S_FIX;
        S_FIX: state_q <= S_EV_CHK;
        S_EV_CHK: state_q <= sts_i.drop_needed ? S_EV_WAIT : S_FINISH;
        S_EV_WAIT: state_q <= S_EV_CHK;
        S_FINISH: if (!sts_i.out_busy) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/drop_oldest_chunk_queue_top.sv
// All transactions pass DECODE and FINISH; an accepted push adds EV_CHK, EV_WAIT and
// EV_CHK per evicted chunk, and MUL, DIV, FIX when trimmed (54-step trim * 1e9 / rate).
// Throughput: one transaction at a time, the next accepted once the result is registered;
// the output register lets a new transaction start while a result waits.
// Reset: asynchronous active low; empties the queue, zeroes statistics, restores limits.
// Depends on docq_pkg, docq_ctrl, docq_dpath.
module drop_oldest_chunk_queue_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  docq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output docq_pkg::out_t out_data_o
);
  import docq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  docq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  docq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/tb_drop_oldest_chunk_queue_top.sv
// Self-checking bench for drop_oldest_chunk_queue_top: directed and random push, pop,
// cancel, restart and clear traffic under several limit settings, checked per field.
// Depends on docq_pkg and the RTL of drop_oldest_chunk_queue_top.
module tb_drop_oldest_chunk_queue_top;
  import docq_pkg::*;

  typedef enum logic [1:0] {
    K_ITEM,
    K_CFG,
    K_DRAIN
  } entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    in_t         item;
    reg_e        idx;
    logic [31:0] data;
  } pending_t;

  localparam logic [63:0] NS_SEC = 64'd1000000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;

  drop_oldest_chunk_queue_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  pending_t pending_q[$];
  out_t     expected_status_q[$];

  // Shadow of the queue state and the limit registers
  logic [20:0]  shadow_len[CHUNK_DEPTH];
  logic [31:0]  shadow_rate[CHUNK_DEPTH];
  logic [63:0]  shadow_start[CHUNK_DEPTH];
  int unsigned  shadow_head;
  int unsigned  shadow_count;
  int unsigned  shadow_total;
  logic [63:0]  drop_ch, drop_sa, reject_ch, enq_ch, enq_sa, deq_ch, deq_sa;
  logic         cancel_q;
  logic [6:0]   chunk_limit_q;
  logic [20:0]  sample_limit_q;
  logic [31:0]  rate_min_q;
  logic [31:0]  rate_max_q;

  // Stimulus-side copy of the limits, used only to shape random pushes
  int unsigned  gen_slim;
  logic [31:0]  gen_rmin;
  logic [31:0]  gen_rmax;

  int unsigned  n_accepted;
  int unsigned  n_results;
  int unsigned  n_cfg;
  int unsigned  n_popped;
  int unsigned  n_trimmed;
  int unsigned  n_errors;
  int unsigned  send_gap;
  int unsigned  recv_stall;
  int unsigned  recv_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned u;
    u = $urandom_range(0, 99);
    if ((n_accepted / 200) % 3 == 2) return 0;
    if (u < 60) return 0;
    if (u < 90) return $urandom_range(1, 3);
    if (u < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] span_ns(logic [63:0] n, logic [31:0] r);
    logic [63:0] whole, rem, d;
    whole = n / r;
    rem   = n % r;
    if (whole > I64_MAX / NS_SEC) return I64_MAX;
    d = whole * NS_SEC + (rem * NS_SEC) / r;
    return (d > I64_MAX) ? I64_MAX : d;
  endfunction

  function automatic void evict_head();
    drop_sa      = drop_sa + shadow_len[shadow_head];
    drop_ch      = drop_ch + 1;
    shadow_total = shadow_total - shadow_len[shadow_head];
    shadow_head  = (shadow_head + 1) % CHUNK_DEPTH;
    shadow_count = shadow_count - 1;
  endfunction

  // Compute the expected result of one transaction and advance the shadow state
  function automatic out_t queue_step(in_t it);
    out_t        r;
    int unsigned len, trim, slim, clim, slot;
    logic [31:0] rmin;
    logic [63:0] start, dur;
    r        = '0;
    r.status = ST_DONE;
    case (it.opcode)
      OP_PUSH: begin
        len  = 32'(it.chunk_length);
        rmin = (rate_min_q == 0) ? 32'd1 : rate_min_q;
        if (len == 0 || it.chunk_rate < rmin || it.chunk_rate > rate_max_q) begin
          reject_ch = reject_ch + 1;
          r.status  = ST_INVALID;
        end else if (cancel_q) begin
          reject_ch = reject_ch + 1;
          r.status  = ST_CANCELLED;
        end else begin
          slim  = (sample_limit_q == 0) ? 1 :
                  (sample_limit_q > SAMPLE_CAPACITY) ? SAMPLE_CAPACITY : sample_limit_q;
          clim  = (chunk_limit_q == 0) ? 1 :
                  (chunk_limit_q > CHUNK_DEPTH) ? CHUNK_DEPTH : chunk_limit_q;
          trim  = (len > slim) ? len - slim : 0;
          start = it.chunk_start_ns;
          if (trim != 0) begin
            len = len - trim;
            dur = span_ns(64'(trim), it.chunk_rate);
            if (dur != 0 && $signed(start) > $signed(I64_MAX - dur)) start = I64_MAX;
            else start = start + dur;
            n_trimmed++;
          end
          while (shadow_count >= clim) evict_head();
          while (shadow_count > 0 && shadow_total > slim - len) evict_head();
          slot               = (shadow_head + shadow_count) % CHUNK_DEPTH;
          shadow_len[slot]   = 21'(len);
          shadow_rate[slot]  = it.chunk_rate;
          shadow_start[slot] = start;
          shadow_count       = shadow_count + 1;
          shadow_total       = shadow_total + len;
          drop_sa            = drop_sa + 64'(trim);
          enq_ch             = enq_ch + 1;
          enq_sa             = enq_sa + 64'(len);
          r.status           = ST_ACCEPTED;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_length   = shadow_len[shadow_head];
          r.out_rate     = shadow_rate[shadow_head];
          r.out_start_ns = shadow_start[shadow_head];
          shadow_total   = shadow_total - shadow_len[shadow_head];
          deq_sa         = deq_sa + shadow_len[shadow_head];
          deq_ch         = deq_ch + 1;
          shadow_head    = (shadow_head + 1) % CHUNK_DEPTH;
          shadow_count   = shadow_count - 1;
          r.status       = ST_POPPED;
          n_popped++;
        end
      end
      OP_CANCEL:  cancel_q = 1'b1;
      OP_RESTART: cancel_q = 1'b0;
      OP_CLEAR: begin
        shadow_head  = 0;
        shadow_count = 0;
        shadow_total = 0;
        {drop_ch, drop_sa, reject_ch, enq_ch, enq_sa, deq_ch, deq_sa} = '0;
        cancel_q     = 1'b0;
      end
      default: ;
    endcase
    r.queued_chunks    = 7'(shadow_count);
    r.queued_samples   = 21'(shadow_total);
    r.dropped_chunks   = drop_ch;
    r.dropped_samples  = drop_sa;
    r.rejected_chunks  = reject_ch;
    r.enqueued_samples = enq_sa;
    r.dequeued_samples = deq_sa;
    r.is_cancelled     = cancel_q;
    return r;
  endfunction

  function automatic void apply_limit(reg_e idx, logic [31:0] data);
    case (idx)
      REG_CHUNK_LIMIT:  chunk_limit_q  = data[6:0];
      REG_SAMPLE_LIMIT: sample_limit_q = data[20:0];
      REG_RATE_MIN:     rate_min_q     = data;
      REG_RATE_MAX:     rate_max_q     = data;
      default: ;
    endcase
  endfunction

  function automatic void check_result(out_t got);
    out_t  want;
    string bad;
    if (expected_status_q.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("unexpected transaction: actual %h", got);
      return;
    end
    want = expected_status_q[0];
    expected_status_q.delete(0);
    bad  = "";
    if (got.status           !== want.status)           bad = {bad, " status"};
    if (got.out_length       !== want.out_length)       bad = {bad, " out_length"};
    if (got.out_rate         !== want.out_rate)         bad = {bad, " out_rate"};
    if (got.out_start_ns     !== want.out_start_ns)     bad = {bad, " out_start_ns"};
    if (got.queued_chunks    !== want.queued_chunks)    bad = {bad, " queued_chunks"};
    if (got.queued_samples   !== want.queued_samples)   bad = {bad, " queued_samples"};
    if (got.dropped_chunks   !== want.dropped_chunks)   bad = {bad, " dropped_chunks"};
    if (got.dropped_samples  !== want.dropped_samples)  bad = {bad, " dropped_samples"};
    if (got.rejected_chunks  !== want.rejected_chunks)  bad = {bad, " rejected_chunks"};
    if (got.enqueued_samples !== want.enqueued_samples) bad = {bad, " enqueued_samples"};
    if (got.dequeued_samples !== want.dequeued_samples) bad = {bad, " dequeued_samples"};
    if (got.is_cancelled     !== want.is_cancelled)     bad = {bad, " is_cancelled"};
    if (bad != "") begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch in result %0d (%s): expected %h actual %h",
                 n_results, bad, want, got);
    end
  endfunction

  // Driver: offer pending transactions, write limits only when nothing is in flight
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_data_i   <= '0;
      cfg_we_i    <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i  <= '0;
    end else begin : drive
      logic     v;
      logic     we;
      pending_t head;
      v  = in_valid_i;
      we = 1'b0;
      if (in_valid_i && in_ready_o) begin
        expected_status_q.insert(expected_status_q.size(), queue_step(in_data_i));
        n_accepted++;
        v = 1'b0;
      end
      if (!v && !cfg_we_i) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          head = pending_q[0];
          if (head.kind == K_ITEM) begin
            in_data_i <= head.item;
            v         = 1'b1;
            pending_q.delete(0);
            send_gap  = pick_gap();
          end else if (expected_status_q.size() == 0) begin
            if (head.kind == K_CFG) begin
              we          = 1'b1;
              cfg_index_i <= head.idx;
              cfg_data_i  <= head.data;
              apply_limit(head.idx, head.data);
              n_cfg++;
            end
            pending_q.delete(0);
          end
        end
      end
      in_valid_i <= v;
      cfg_we_i   <= we;
    end
  end

  // Monitor: accept results with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin : monitor
      logic r;
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        n_results++;
        if (n_results == 500) recv_hold = 400;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        r = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        r = 1'b0;
      end else begin
        r          = 1'b1;
        recv_stall = pick_gap();
      end
      out_ready_i <= r;
    end
  end

  task automatic add_item(logic [2:0] op, logic [23:0] len, logic [31:0] rate,
                          logic [63:0] start);
    pending_t p;
    p.kind                = K_ITEM;
    p.item.opcode         = op;
    p.item.chunk_length   = len;
    p.item.chunk_rate     = rate;
    p.item.chunk_start_ns = start;
    p.idx                 = REG_CHUNK_LIMIT;
    p.data                = '0;
    pending_q.insert(pending_q.size(), p);
  endtask

  task automatic add_limit(reg_e idx, logic [31:0] data);
    pending_t p;
    p.kind = K_CFG;
    p.item = '0;
    p.idx  = idx;
    p.data = data;
    pending_q.insert(pending_q.size(), p);
    case (idx)
      REG_SAMPLE_LIMIT: gen_slim = (data[20:0] == 0) ? 1 :
                                   (data[20:0] > SAMPLE_CAPACITY) ? SAMPLE_CAPACITY : data[20:0];
      REG_RATE_MIN:     gen_rmin = data;
      REG_RATE_MAX:     gen_rmax = data;
      default: ;
    endcase
  endtask

  task automatic add_limits(logic [31:0] clim, logic [31:0] slim, logic [31:0] rmin,
                            logic [31:0] rmax);
    add_limit(REG_CHUNK_LIMIT, clim);
    add_limit(REG_SAMPLE_LIMIT, slim);
    add_limit(REG_RATE_MIN, rmin);
    add_limit(REG_RATE_MAX, rmax);
  endtask

  task automatic add_drain();
    pending_t p;
    p.kind = K_DRAIN;
    p.item = '0;
    p.idx  = REG_CHUNK_LIMIT;
    p.data = '0;
    pending_q.insert(pending_q.size(), p);
  endtask

  // Random push with lengths and rates aimed at the current limits
  task automatic add_random_push();
    int unsigned u;
    logic [23:0] len;
    logic [31:0] rate, lo;
    logic [63:0] start;
    u  = $urandom_range(0, 99);
    lo = (gen_rmin == 0) ? 32'd1 : gen_rmin;
    if (u < 5)       len = 0;
    else if (u < 12) len = 24'(gen_slim + $urandom_range(1, 3000));
    else if (u < 15) len = 24'($urandom());
    else             len = 24'($urandom_range(1, gen_slim / 8 + 1));
    u = $urandom_range(0, 99);
    if (u < 6)       rate = $urandom();
    else if (u < 9)  rate = 0;
    else if (u < 12) rate = u[0] ? lo : gen_rmax;
    else if (u < 14) rate = u[0] ? lo - 1 : gen_rmax + 1;
    else if (lo > gen_rmax) rate = $urandom();
    else             rate = lo + $urandom_range(0, gen_rmax - lo);
    u = $urandom_range(0, 99);
    if (u < 10)      start = I64_MAX - $urandom_range(0, 1000);
    else if (u < 15) start = {1'b1, 63'd0} + $urandom_range(0, 1000);
    else             start = {$urandom(), $urandom()};
    add_item(OP_PUSH, len, rate, start);
  endtask

  task automatic add_random(int unsigned count, int unsigned pop_pct);
    int unsigned u;
    logic [2:0]  op;
    for (int i = 0; i < count; i++) begin
      u = $urandom_range(0, 99);
      if (u < pop_pct) begin
        add_item(OP_POP, 24'($urandom()), $urandom(), {$urandom(), $urandom()});
      end else if (u < 88) begin
        add_random_push();
      end else begin
        op = (u < 92) ? OP_CANCEL : (u < 97) ? OP_RESTART : (u < 98) ? OP_CLEAR :
             3'($urandom_range(5, 7));
        add_item(op, 24'($urandom()), $urandom(), {$urandom(), $urandom()});
      end
    end
  endtask

  // Stimulus plan and end of run
  initial begin
    gen_slim = SAMPLE_CAPACITY;
    gen_rmin = 32'd8000;
    gen_rmax = 32'd192000;
    {shadow_head, shadow_count, shadow_total} = '0;
    {drop_ch, drop_sa, reject_ch, enq_ch, enq_sa, deq_ch, deq_sa} = '0;
    cancel_q       = 1'b0;
    chunk_limit_q  = 7'd64;
    sample_limit_q = 21'(SAMPLE_CAPACITY);
    rate_min_q     = 32'd8000;
    rate_max_q     = 32'd192000;
    {n_accepted, n_results, n_cfg, n_popped, n_trimmed, n_errors} = '0;
    {send_gap, recv_stall, recv_hold} = '0;

    // Directed: boundaries, rejections in check order, trims, undefined opcodes
    add_item(OP_POP, 0, 0, 0);
    add_item(OP_PUSH, 1, 8000, 0);
    add_item(OP_PUSH, 24'd1048576, 192000, {1'b1, 63'd0});
    add_item(OP_PUSH, 0, 8000, 5);
    add_item(OP_PUSH, 10, 7999, 5);
    add_item(OP_PUSH, 10, 192001, 5);
    add_item(OP_PUSH, 10, 0, 5);
    add_item(OP_POP, 0, 0, 0);
    add_item(OP_CANCEL, 0, 0, 0);
    add_item(OP_PUSH, 10, 48000, 7);
    add_item(OP_PUSH, 0, 48000, 7);
    add_item(OP_RESTART, 0, 0, 0);
    add_item(OP_PUSH, 24'hFFFFFF, 8000, I64_MAX - 5);
    add_item(OP_PUSH, 24'd1048577, 192000, 64'hFFFF_FFFF_FFFF_FF00);
    add_item(OP_PUSH, 24'd2000000, 44100, 64'd123456789);
    add_item(OP_POP, 0, 0, 0);
    add_item(OP_POP, 0, 0, 0);
    add_item(3'd5, 24'hFFFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(3'd6, 0, 0, 0);
    add_item(3'd7, 0, 0, 0);
    add_item(OP_CLEAR, 0, 0, 0);
    add_item(OP_POP, 0, 0, 0);
    add_random(230, 30);

    // Tight limits, zero rate_min
    add_limits(4, 5000, 0, 48000);
    add_item(OP_PUSH, 1, 0, 0);
    add_random(250, 25);
    // Smallest limits
    add_limits(1, 1, 1, 32'hFFFF_FFFF);
    add_random(200, 30);
    add_drain();
    // Largest legal limits, full rate range
    add_limits(64, SAMPLE_CAPACITY, 1, 32'hFFFF_FFFF);
    add_random(300, 20);
    // Out of range limits clamp, single legal rate
    add_limits(127, 32'h1F_FFFF, 44100, 44100);
    add_random(200, 30);
    // Limits of zero, rate window inverted
    add_limits(0, 0, 96000, 8000);
    add_random(60, 30);
    // Fill, then lower limits below occupancy
    add_limits(16, 20000, 8000, 192000);
    add_item(OP_CLEAR, 0, 0, 0);
    for (int i = 0; i < 16; i++) add_item(OP_PUSH, 24'(500 + i), 16000, 64'(i));
    add_limits(3, 2000, 8000, 192000);
    add_random(300, 35);
    add_limits(64, SAMPLE_CAPACITY, 8000, 192000);
    add_random(200, 30);

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || in_valid_i || expected_status_q.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (expected_status_q.size() != 0) n_errors += expected_status_q.size();
    $display("covered %0d transactions over %0d limit writes, %0d pops with data, %0d trims",
             n_accepted, n_cfg, n_popped, n_trimmed);
    $display("%0d results checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("[drop_oldest_chunk_queue_top] OK");
    end else begin
      $display("[drop_oldest_chunk_queue_top] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30000000;
    $display("[drop_oldest_chunk_queue_top] ERROR");
    $finish;
  end

endmodule

>>> files.f
hdl/docq_pkg.sv
hdl/docq_dpath.sv
hdl/docq_ctrl.sv
hdl/drop_oldest_chunk_queue_top.sv
bench/tb_drop_oldest_chunk_queue_top.sv
